>>> rtl/tsg_pkg.sv
package tsg_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PRESSED = 2'd1,
    MODE_HOLDING = 2'd2,
    MODE_SLIDING = 2'd3
  } mode_t;

  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_CALC    = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  localparam logic [2:0] G_TAP           = 3'd0;
  localparam logic [2:0] G_HOLD          = 3'd1;
  localparam logic [2:0] G_HOLD_RELEASE  = 3'd2;
  localparam logic [2:0] G_SLIDE_MOVE    = 3'd3;
  localparam logic [2:0] G_SLIDE_RELEASE = 3'd4;

  localparam logic       REG_MOVE_THRESHOLD = 1'b0;
  localparam logic       REG_HOLD_TIME      = 1'b1;

  localparam logic [7:0]  MOVE_THRESHOLD_RST = 8'd10;
  localparam logic [15:0] HOLD_TIME_RST      = 16'd1000;
  localparam logic [7:0]  START_POSITION_RST = 8'd50;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  position;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] gesture;
    logic [7:0] gesture_position;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  move_threshold;
    logic [15:0] hold_time;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

>>> rtl/tsg_cfg.sv
module tsg_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output tsg_pkg::cfg_t       cfg
);

  logic [7:0]  move_threshold_r;
  logic [15:0] hold_time_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_threshold_r <= tsg_pkg::MOVE_THRESHOLD_RST;
      hold_time_r      <= tsg_pkg::HOLD_TIME_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        tsg_pkg::REG_MOVE_THRESHOLD: move_threshold_r <= pwdata[7:0];
        tsg_pkg::REG_HOLD_TIME:      hold_time_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      tsg_pkg::REG_MOVE_THRESHOLD: prdata = {24'd0, move_threshold_r};
      tsg_pkg::REG_HOLD_TIME:      prdata = {16'd0, hold_time_r};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg.move_threshold = move_threshold_r;
  assign cfg.hold_time      = hold_time_r;

endmodule

>>> rtl/tsg_classify.sv
module tsg_classify #(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                item_valid,
  input  tsg_pkg::in_item_t   item,
  input  tsg_pkg::cfg_t       cfg,
  output tsg_pkg::result_t    res
);

  tsg_pkg::mode_t         mode_r, mode_nxt;
  logic [7:0]             start_pos_r, start_pos_nxt;
  logic [TIME_BITS-1:0]   start_time_r, start_time_nxt;

  logic [TIME_BITS+31:0]  now_wide;
  logic [TIME_BITS-1:0]   now_t;
  logic [TIME_BITS-1:0]   elapsed;
  logic signed [9:0]      pos_delta;
  logic signed [9:0]      thr;
  logic                   far;
  logic                   near;
  logic                   hold_due;
  logic                   is_press, is_calc, is_release;

  // timestamp folded to the configured time width
  assign now_wide = {{TIME_BITS{1'b0}}, item.now_ms};
  assign now_t    = now_wide[TIME_BITS-1:0];
  assign elapsed  = now_t - start_time_r;
  assign hold_due = elapsed > {{(TIME_BITS-16){1'b0}}, cfg.hold_time};

  assign pos_delta = $signed({2'b00, item.position}) - $signed({2'b00, start_pos_r});
  assign thr  = $signed({2'b00, cfg.move_threshold});
  assign far  = (pos_delta > thr) || (pos_delta < -thr);
  assign near = (pos_delta < thr) && (pos_delta > -thr);

  assign is_press   = item_valid && (item.kind == tsg_pkg::EV_PRESS);
  assign is_calc    = item_valid && (item.kind == tsg_pkg::EV_CALC);
  assign is_release = item_valid && (item.kind == tsg_pkg::EV_RELEASE);

  always_comb begin
    mode_nxt       = mode_r;
    start_pos_nxt  = start_pos_r;
    start_time_nxt = start_time_r;
    unique case (mode_r)
      tsg_pkg::MODE_IDLE: begin
        if (is_press) begin
          mode_nxt       = tsg_pkg::MODE_PRESSED;
          start_pos_nxt  = item.position;
          start_time_nxt = now_t;
        end
      end
      tsg_pkg::MODE_PRESSED: begin
        priority if (is_calc && far) begin
          mode_nxt = tsg_pkg::MODE_SLIDING;
        end else if (is_calc && hold_due) begin
          mode_nxt = tsg_pkg::MODE_HOLDING;
        end else if (is_release) begin
          mode_nxt = tsg_pkg::MODE_IDLE;
        end else begin
          mode_nxt = mode_r;
        end
      end
      tsg_pkg::MODE_HOLDING,
      tsg_pkg::MODE_SLIDING: begin
        if (is_release) begin
          mode_nxt = tsg_pkg::MODE_IDLE;
        end
      end
      default: mode_nxt = tsg_pkg::MODE_IDLE;
    endcase
  end

  always_comb begin
    res.valid                 = 1'b0;
    res.item.gesture          = tsg_pkg::G_TAP;
    res.item.gesture_position = item.position;
    unique case (mode_r)
      tsg_pkg::MODE_IDLE: res.valid = 1'b0;
      tsg_pkg::MODE_PRESSED: begin
        res.valid        = is_release && near;
        res.item.gesture = tsg_pkg::G_TAP;
      end
      tsg_pkg::MODE_HOLDING: begin
        res.valid        = is_calc || is_release;
        res.item.gesture = is_release ? tsg_pkg::G_HOLD_RELEASE : tsg_pkg::G_HOLD;
      end
      tsg_pkg::MODE_SLIDING: begin
        res.valid        = is_calc || is_release;
        res.item.gesture = is_release ? tsg_pkg::G_SLIDE_RELEASE : tsg_pkg::G_SLIDE_MOVE;
      end
      default: res.valid = 1'b0;
    endcase
  end

  // state moves only when the event leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= tsg_pkg::MODE_IDLE;
      start_pos_r  <= tsg_pkg::START_POSITION_RST;
      start_time_r <= '0;
    end else if (advance) begin
      mode_r       <= mode_nxt;
      start_pos_r  <= start_pos_nxt;
      start_time_r <= start_time_nxt;
    end
  end

endmodule

>>> rtl/touch_slider_gesture_classifier.sv
// Touch slider gesture classifier: turns press, update and release events into tap, hold,
// hold release, slide move and slide release gestures. One event is taken every clock unless
// in_stall holds it while the output is stalled; an event is held in the input register,
// where the gesture state (mode, start position, start time) is evaluated and updated, and
// any gesture is then registered in the output register once the output is not stalled.
// Events that make no gesture produce no output beat. TIME_BITS sets the width of the stored
// start time and of the wrapping elapsed-time subtraction.
module touch_slider_gesture_classifier #(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsg_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tsg_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  tsg_pkg::cfg_t      cfg;
  tsg_pkg::result_t   res;
  tsg_pkg::in_item_t  in_item_r;
  tsg_pkg::out_item_t out_item_r;
  logic               in_valid_r;
  logic               out_valid_r;
  logic               advance;
  logic               in_take;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  tsg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsg_classify #(
    .TIME_BITS (TIME_BITS)
  ) u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .item_valid (in_valid_r),
    .item       (in_item_r),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

>>> dv/touch_slider_gesture_classifier_test.sv
`timescale 1ns / 1ps

module touch_slider_gesture_classifier_test;
  import tsg_pkg::*;

  localparam logic [1:0] EV_UNKNOWN = 2'd3;
  localparam int SETTLE = 4;       // event register plus output register, with margin
  localparam int QUIET_LIMIT = 600;
  localparam int PHASE_EVENTS = 84;

  // script row tags
  localparam bit EVT = 1'b0, CFG = 1'b1;
  localparam bit FREE = 1'b0, PIN = 1'b1;
  localparam bit NONE = 1'b0, GEST = 1'b1;

  typedef struct {
    bit          is_cfg;   // config rows carry threshold in pos and hold time in ms
    logic [1:0]  kind;
    logic [7:0]  pos;
    logic [31:0] ms;
    bit          pinned;
    bit          has;
    logic [2:0]  gest;
  } row_t;

  typedef struct {
    bit        pinned;
    bit        has;
    out_item_t g;
  } fixed_gesture_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  touch_slider_gesture_classifier u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // gesture tracker state and its register copies
  mode_t       mode_now;
  logic [7:0]  anchor_pos;
  logic [31:0] anchor_ms;
  logic [7:0]  move_thr;
  logic [15:0] hold_ms;

  out_item_t      gestures_due [$];
  fixed_gesture_t fixed_q [$];

  int  errors = 0;
  int  n_sent = 0;
  int  n_events = 0;
  int  n_gestures = 0;
  int  n_settings = 0;
  int  seen [5] = '{0, 0, 0, 0, 0};
  bit  send_gaps = 1'b1;
  bit  take_gaps = 1'b1;

  row_t script [31] = '{
    '{EVT, EV_RELEASE, 8'd0,   32'h0000_0000, PIN,  NONE, G_TAP},
    '{EVT, EV_CALC,    8'd255, 32'h0000_0000, PIN,  NONE, G_TAP},
    '{EVT, EV_UNKNOWN, 8'd50,  32'h0000_0000, PIN,  NONE, G_TAP},
    '{EVT, EV_PRESS,   8'd100, 32'hFFFF_FF00, PIN,  NONE, G_TAP},
    '{EVT, EV_PRESS,   8'd200, 32'h0000_0000, PIN,  NONE, G_TAP},
    '{EVT, EV_CALC,    8'd110, 32'hFFFF_FF10, FREE, NONE, G_TAP},
    '{EVT, EV_RELEASE, 8'd109, 32'h0000_0000, PIN,  GEST, G_TAP},
    '{EVT, EV_PRESS,   8'd0,   32'h0000_0000, PIN,  NONE, G_TAP},
    '{EVT, EV_RELEASE, 8'd10,  32'h0000_0000, PIN,  NONE, G_TAP},
    '{EVT, EV_PRESS,   8'd255, 32'hFFFF_FFF0, FREE, NONE, G_TAP},
    // elapsed wraps through zero: exactly the hold time, then one past it
    '{EVT, EV_CALC,    8'd255, 32'h0000_03D8, FREE, NONE, G_TAP},
    '{EVT, EV_CALC,    8'd245, 32'h0000_03D9, FREE, NONE, G_TAP},
    '{EVT, EV_CALC,    8'd3,   32'h0000_0000, PIN,  GEST, G_HOLD},
    '{EVT, EV_UNKNOWN, 8'd0,   32'h0000_0000, PIN,  NONE, G_TAP},
    '{EVT, EV_RELEASE, 8'd7,   32'h0000_0000, PIN,  GEST, G_HOLD_RELEASE},
    '{EVT, EV_PRESS,   8'd128, 32'h0000_0005, FREE, NONE, G_TAP},
    '{EVT, EV_CALC,    8'd139, 32'h0000_0005, FREE, NONE, G_TAP},
    '{EVT, EV_CALC,    8'd0,   32'hFFFF_FFFF, PIN,  GEST, G_SLIDE_MOVE},
    '{EVT, EV_PRESS,   8'd1,   32'h0000_0000, PIN,  NONE, G_TAP},
    '{EVT, EV_RELEASE, 8'd255, 32'h0000_0000, PIN,  GEST, G_SLIDE_RELEASE},
    '{CFG, EV_PRESS,   8'd0,   32'h0000_0000, FREE, NONE, G_TAP},
    '{EVT, EV_PRESS,   8'd50,  32'h1234_5678, FREE, NONE, G_TAP},
    // zero threshold: a release in place is never a tap
    '{EVT, EV_RELEASE, 8'd50,  32'h0000_0000, PIN,  NONE, G_TAP},
    '{EVT, EV_PRESS,   8'd50,  32'h0000_0007, FREE, NONE, G_TAP},
    '{EVT, EV_CALC,    8'd50,  32'h0000_0007, FREE, NONE, G_TAP},
    '{EVT, EV_CALC,    8'd50,  32'h0000_0008, FREE, NONE, G_TAP},
    '{EVT, EV_RELEASE, 8'd51,  32'h0000_0000, PIN,  GEST, G_HOLD_RELEASE},
    '{CFG, EV_PRESS,   8'd255, 32'h0000_FFFF, FREE, NONE, G_TAP},
    '{EVT, EV_PRESS,   8'd0,   32'h0000_0000, FREE, NONE, G_TAP},
    '{EVT, EV_CALC,    8'd255, 32'h0000_FFFF, FREE, NONE, G_TAP},
    '{EVT, EV_RELEASE, 8'd254, 32'h0000_0000, PIN,  GEST, G_TAP}
  };

  function automatic bit count_error();
    errors++;
    return errors <= 10;
  endfunction

  function automatic bit classify_event(input in_item_t ev, output out_item_t g);
    int          delta;
    int          thr;
    logic [31:0] elapsed;
    delta = int'(ev.position) - int'(anchor_pos);
    thr = int'(move_thr);
    g.gesture = G_TAP;
    g.gesture_position = ev.position;
    classify_event = 1'b0;
    case (mode_now)
      MODE_IDLE: begin
        if (ev.kind == EV_PRESS) begin
          anchor_ms = ev.now_ms;
          anchor_pos = ev.position;
          mode_now = MODE_PRESSED;
        end
      end
      MODE_PRESSED: begin
        if (ev.kind == EV_CALC) begin
          elapsed = ev.now_ms - anchor_ms;
          if (delta > thr || delta < -thr) mode_now = MODE_SLIDING;
          else if (elapsed > 32'(hold_ms)) mode_now = MODE_HOLDING;
        end else if (ev.kind == EV_RELEASE) begin
          mode_now = MODE_IDLE;
          if (delta < thr && delta > -thr) classify_event = 1'b1;
        end
      end
      MODE_HOLDING: begin
        if (ev.kind == EV_CALC) begin
          g.gesture = G_HOLD;
          classify_event = 1'b1;
        end else if (ev.kind == EV_RELEASE) begin
          mode_now = MODE_IDLE;
          g.gesture = G_HOLD_RELEASE;
          classify_event = 1'b1;
        end
      end
      default: begin
        if (ev.kind == EV_CALC) begin
          g.gesture = G_SLIDE_MOVE;
          classify_event = 1'b1;
        end else if (ev.kind == EV_RELEASE) begin
          mode_now = MODE_IDLE;
          g.gesture = G_SLIDE_RELEASE;
          classify_event = 1'b1;
        end
      end
    endcase
  endfunction

  // both channels are sampled here; values read are the ones before the edge
  always @(posedge clk) begin : beats
    fixed_gesture_t note;
    out_item_t      want;
    bit             hit;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (gestures_due.size() == 0) begin
          if (count_error())
            $display("unexpected gesture %0d at position %0d", out_data.gesture,
                     out_data.gesture_position);
        end else begin
          want = gestures_due.pop_front();
          if (out_data.gesture !== want.gesture ||
              out_data.gesture_position !== want.gesture_position) begin
            if (count_error())
              $display("gesture beat %0d: expected gesture %0d pos %0d, got gesture %0d pos %0d",
                       n_gestures, want.gesture, want.gesture_position, out_data.gesture,
                       out_data.gesture_position);
          end
        end
        n_gestures++;
        if (out_data.gesture <= G_SLIDE_RELEASE) seen[out_data.gesture]++;
      end
      if (in_valid && !in_stall) begin
        note = fixed_q.pop_front();
        hit = classify_event(in_data, want);
        if (note.pinned) begin
          hit = note.has;
          want = note.g;
        end
        if (hit) gestures_due.push_back(want);
        n_events++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
    $display("touch_slider_gesture_classifier_test: done, errors");
    $finish;
  end

  // result side: a fresh stall draw after every accepted beat
  initial begin : gesture_sink
    int gap;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      gap = take_gaps ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic apb_access(input logic wr, input logic sel, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {sel, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic sel, input logic [31:0] want);
    logic [31:0] got;
    apb_access(1'b0, sel, 32'd0, got);
    if (got !== want)
      if (count_error()) $display("register %0d reads %h, expected %h", sel, got, want);
  endtask

  task automatic program_limits(input logic [7:0] thr, input logic [15:0] hold);
    logic [31:0] unused;
    apb_access(1'b1, REG_MOVE_THRESHOLD, {24'd0, thr}, unused);
    apb_access(1'b1, REG_HOLD_TIME, {16'd0, hold}, unused);
    move_thr = thr;
    hold_ms = hold;
    check_reg(REG_MOVE_THRESHOLD, {24'd0, thr});
    check_reg(REG_HOLD_TIME, {16'd0, hold});
    n_settings++;
  endtask

  task automatic send_event(input in_item_t ev, input bit pinned, input bit has,
                            input logic [2:0] gest);
    int             gap;
    fixed_gesture_t note;
    gap = send_gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note.pinned = pinned;
    note.has = has;
    note.g = '{gest, ev.position};
    fixed_q.push_back(note);
    in_valid <= 1'b1;
    in_data <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // stop sending and wait for every pending gesture, then let the pipe settle
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (gestures_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_pos(input logic [7:0] base);
    int p;
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    // mostly around the threshold edge so tap, hold and slide all show up
    p = int'(base) + int'($urandom_range(0, 2 * move_thr + 2)) - int'(move_thr) - 1;
    if (p < 0) p = 0;
    if (p > 255) p = 255;
    return 8'(p);
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, hold_ms);
      1: return 32'(hold_ms);
      2: return 32'(hold_ms) + 32'd1;
      default: return $urandom_range(hold_ms, 2 * hold_ms + 50);
    endcase
  endfunction

  task automatic play_touch();
    in_item_t    ev;
    logic [7:0]  origin;
    logic [31:0] t0;
    int          moves;
    origin = 8'($urandom_range(0, 255));
    t0 = $urandom;
    ev = '{EV_PRESS, origin, t0};
    send_event(ev, FREE, NONE, G_TAP);
    moves = $urandom_range(0, 6);
    repeat (moves) begin
      ev = '{EV_CALC, pick_pos(origin), t0 + pick_offset()};
      send_event(ev, FREE, NONE, G_TAP);
    end
    // now and then the release is lost, leaving the next press to be ignored
    if ($urandom_range(0, 7) != 0) begin
      ev = '{EV_RELEASE, pick_pos(origin), t0 + pick_offset()};
      send_event(ev, FREE, NONE, G_TAP);
    end
  endtask

  initial begin : stimulus
    in_item_t    ev;
    int          start;
    bit          paused;
    logic [7:0]  thr;
    logic [15:0] hold;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    mode_now = MODE_IDLE;
    anchor_pos = START_POSITION_RST;
    anchor_ms = '0;
    move_thr = MOVE_THRESHOLD_RST;
    hold_ms = HOLD_TIME_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    check_reg(REG_MOVE_THRESHOLD, {24'd0, MOVE_THRESHOLD_RST});
    check_reg(REG_HOLD_TIME, {16'd0, HOLD_TIME_RST});

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain(SETTLE);
        program_limits(script[i].pos, script[i].ms[15:0]);
      end else begin
        ev = '{script[i].kind, script[i].pos, script[i].ms};
        send_event(ev, script[i].pinned, script[i].has, script[i].gest);
      end
    end
    drain(SETTLE);

    paused = 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin thr = MOVE_THRESHOLD_RST; hold = HOLD_TIME_RST; end
        1: begin thr = 8'd0; hold = 16'd0; end
        2: begin thr = 8'd255; hold = 16'hFFFF; end
        5: begin thr = 8'd3; hold = 16'd20; end
        default: begin
          thr = 8'($urandom_range(1, 40));
          hold = 16'($urandom_range(1, 3000));
        end
      endcase
      program_limits(thr, hold);
      start = n_sent;
      while (n_sent - start < PHASE_EVENTS) begin
        send_gaps = ($urandom_range(0, 3) != 0);
        take_gaps = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) == 0) begin
          ev = '{2'($urandom_range(0, 3)), 8'($urandom), $urandom};
          send_event(ev, FREE, NONE, G_TAP);
        end else begin
          play_touch();
        end
        if (ph == 3 && !paused && n_sent - start > PHASE_EVENTS / 2) begin
          drain(0);
          paused = 1'b1;
        end
      end
      drain(SETTLE);
    end

    $display("covered %0d events over %0d threshold/hold settings, zero and full scale included",
             n_events, n_settings);
    $display("gestures seen: tap %0d, hold %0d, hold release %0d, slide move %0d, slide release %0d",
             seen[0], seen[1], seen[2], seen[3], seen[4]);
    if (errors == 0) begin
      $display("touch_slider_gesture_classifier_test: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("touch_slider_gesture_classifier_test: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tsg_pkg.sv
rtl/tsg_cfg.sv
rtl/tsg_classify.sv
rtl/touch_slider_gesture_classifier.sv
dv/touch_slider_gesture_classifier_test.sv
